[design/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Slot count, field widths, mode and result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none
package stq_pkg;
  localparam int TimerSlots = 16;
  localparam int SlotW      = $clog2(TimerSlots);
  localparam int CntW       = $clog2(TimerSlots + 1);
  localparam int MaxOut     = 16;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_ADDED   = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture input beat
    logic div_start;  // start delay conversion
    logic tick_inc;   // advance tick count
    logic scan_clr;   // reset scan pointer and best
    logic scan_step;  // examine one slot
    logic do_add;     // write entry at free slot
    logic do_update;  // rewrite expiry
    logic do_remove;  // clear scanned slot if task matches
    logic do_free;    // free best slot
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic have_best;
    logic have_more;  // a second due entry was seen in this scan
    logic have_free;
    logic upd_ok;
    mode_e mode;
  } dp_sts_t;
endpackage
`default_nettype wire

[design/stq_datapath.sv]
// ----------------------------------------------------------------------------
// stq_datapath: timer table, tick counter, serial divider and slot scanner
// One slot is examined per cycle; division retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stq_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [9:0]            ms_per_tick_i,
  input  wire logic [1:0]            mode_i,
  input  wire logic [7:0]            task_id_i,
  input  wire logic [31:0]           delay_ms_i,
  input  wire logic [3:0]            slot_handle_i,
  input  wire logic                  has_handler_i,
  input  wire logic [7:0]            handler_tag_i,
  input  wire stq_pkg::dp_cmd_t      cmd_i,
  output stq_pkg::dp_sts_t           sts_o,
  output logic [stq_pkg::SlotW-1:0]  best_o,
  output logic [stq_pkg::SlotW-1:0]  free_o,
  output logic [7:0]                 best_task_o,
  output logic                       best_hh_o,
  output logic [7:0]                 best_tag_o
);
  import stq_pkg::*;

  logic [TimerSlots-1:0] valid_q;
  logic [31:0] expiry_q [TimerSlots];
  logic [7:0]  task_q   [TimerSlots];
  logic        hh_q     [TimerSlots];
  logic [7:0]  tag_q    [TimerSlots];

  logic [31:0] tick_q;
  logic [1:0]  mode_q;
  logic [7:0]  in_task_q, in_tag_q;
  logic        in_hh_q;
  logic [3:0]  in_handle_q;

  // restoring divider
  logic [31:0] quo_q, rem_q;
  logic [9:0]  div_q;
  logic [5:0]  div_cnt_q;
  logic        div_busy_q;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  // scanner
  logic [CntW-1:0]  ptr_q;
  logic [SlotW-1:0] idx;
  logic [SlotW-1:0] best_q, free_q;
  logic             have_best_q, have_free_q, have_more_q;
  logic             elig;
  logic             cand;

  assign idx     = ptr_q[SlotW-1:0];
  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {23'd0, div_q};
  assign elig    = valid_q[idx] && (expiry_q[idx] <= tick_q);
  // strict compare keeps the lowest slot on ties
  assign cand = elig && (!have_best_q || (expiry_q[idx] < expiry_q[best_q]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      tick_q      <= '0;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
      ptr_q       <= '0;
      have_best_q <= 1'b0;
      have_free_q <= 1'b0;
      have_more_q <= 1'b0;
      mode_q      <= MODE_TICK;
    end else begin
      if (cmd_i.load_in) begin
        mode_q      <= mode_i;
        in_task_q   <= task_id_i;
        in_hh_q     <= has_handler_i;
        in_tag_q    <= has_handler_i ? handler_tag_i : 8'd0;
        in_handle_q <= slot_handle_i;
        quo_q       <= delay_ms_i;
        rem_q       <= '0;
        div_q       <= (ms_per_tick_i == 10'd0) ? 10'd1 : ms_per_tick_i;
      end
      if (cmd_i.div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= '0;
      end else if (div_busy_q) begin
        if (!rem_sub[32]) begin
          rem_q <= rem_sub[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
        div_cnt_q <= div_cnt_q + 6'd1;
        if (div_cnt_q == 6'd31) div_busy_q <= 1'b0;
      end
      if (cmd_i.tick_inc) tick_q <= tick_q + 32'd1;
      if (cmd_i.scan_clr) begin
        ptr_q       <= '0;
        have_best_q <= 1'b0;
        have_free_q <= 1'b0;
        have_more_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        ptr_q <= ptr_q + CntW'(1);
        if (cand) begin
          have_best_q <= 1'b1;
          best_q      <= idx;
        end
        if (elig && have_best_q) have_more_q <= 1'b1;
        if (!valid_q[idx] && !have_free_q) begin
          have_free_q <= 1'b1;
          free_q      <= idx;
        end
        if (cmd_i.do_remove && valid_q[idx] && task_q[idx] == in_task_q)
          valid_q[idx] <= 1'b0;
      end
      if (cmd_i.do_add) valid_q[free_q] <= 1'b1;
      if (cmd_i.do_free) valid_q[best_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      expiry_q[free_q] <= tick_q + quo_q;
      task_q[free_q]   <= in_task_q;
      hh_q[free_q]     <= in_hh_q;
      tag_q[free_q]    <= in_tag_q;
    end
    if (cmd_i.do_update) expiry_q[in_handle_q[SlotW-1:0]] <= tick_q + quo_q;
  end

  always_comb begin
    sts_o.div_done  = !div_busy_q;
    sts_o.scan_done = (ptr_q == CntW'(TimerSlots));
    sts_o.have_best = have_best_q;
    sts_o.have_more = have_more_q;
    sts_o.have_free = have_free_q;
    sts_o.upd_ok    = (32'(in_handle_q) < 32'(TimerSlots)) &&
                      valid_q[in_handle_q[SlotW-1:0]];
    sts_o.mode      = mode_e'(mode_q);
  end

  assign best_o      = best_q;
  assign free_o      = free_q;
  assign best_task_o = task_q[best_q];
  assign best_hh_o   = hh_q[best_q];
  assign best_tag_o  = tag_q[best_q];
endmodule
`default_nettype wire

[design/stq_ctrl.sv]
// ----------------------------------------------------------------------------
// stq_ctrl: sequencer of the sorted timer queue
// Steps each operation through the datapath and builds the result beats.
// ----------------------------------------------------------------------------
`default_nettype none
module stq_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [3:0]                 out_handle_o,
  output logic [7:0]                 out_task_o,
  output logic                       out_has_handler_o,
  output logic [7:0]                 out_handler_tag_o,
  output logic                       last_o,
  output stq_pkg::dp_cmd_t           cmd_o,
  input  wire stq_pkg::dp_sts_t      sts_i,
  input  wire logic [stq_pkg::SlotW-1:0] best_i,
  input  wire logic [stq_pkg::SlotW-1:0] free_i,
  input  wire logic [7:0]            best_task_i,
  input  wire logic                  best_hh_i,
  input  wire logic [7:0]            best_tag_i
);
  import stq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_DIV, S_SCAN, S_DECIDE, S_OUT
  } state_e;

  state_e state_q;
  logic [4:0] nout_q;     // expired beats sent this tick
  logic       more_q;     // after this beat, scan again
  logic       out_busy;

  assign out_busy   = out_valid_o && out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:     cmd_o.load_in = in_valid_i;
      S_DISPATCH: begin
        cmd_o.scan_clr = 1'b1;
        cmd_o.div_start = (sts_i.mode == MODE_ADD) || (sts_i.mode == MODE_UPDATE);
        cmd_o.tick_inc  = (sts_i.mode == MODE_TICK);
      end
      S_SCAN: begin
        cmd_o.scan_step = !sts_i.scan_done;
        cmd_o.do_remove = (sts_i.mode == MODE_REMOVE);
      end
      S_DECIDE: begin
        cmd_o.do_add    = (sts_i.mode == MODE_ADD) && sts_i.have_free && !out_busy;
        cmd_o.do_update = (sts_i.mode == MODE_UPDATE) && sts_i.upd_ok && !out_busy;
        cmd_o.do_free   = (sts_i.mode == MODE_TICK) && sts_i.have_best && !out_busy;
      end
      S_OUT: cmd_o.scan_clr = !out_busy && more_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      nout_q      <= '0;
      more_q      <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DISPATCH;
        S_DISPATCH: begin
          nout_q <= '0;
          if (sts_i.mode == MODE_ADD) state_q <= S_SCAN;  // find free slot first
          else if (sts_i.mode == MODE_UPDATE) state_q <= S_DIV;
          else state_q <= S_SCAN;
        end
        S_DIV: if (sts_i.div_done) state_q <= S_DECIDE;
        S_SCAN: if (sts_i.scan_done) begin
          state_q <= (sts_i.mode == MODE_ADD) ? S_DIV : S_DECIDE;
        end
        S_DECIDE: if (!out_busy) begin
          out_valid_o       <= 1'b1;
          out_handle_o      <= '0;
          out_task_o        <= '0;
          out_has_handler_o <= 1'b0;
          out_handler_tag_o <= '0;
          last_o            <= 1'b1;
          more_q            <= 1'b0;
          state_q           <= S_OUT;
          unique case (sts_i.mode)
            MODE_ADD: begin
              kind_o <= sts_i.have_free ? KIND_ADDED : KIND_ERROR;
              out_handle_o <= sts_i.have_free ? 4'(free_i) : 4'd0;
            end
            MODE_UPDATE: kind_o <= sts_i.upd_ok ? KIND_ACK : KIND_ERROR;
            MODE_REMOVE: kind_o <= KIND_ACK;
            MODE_TICK: begin
              if (sts_i.have_best) begin
                kind_o            <= KIND_EXPIRED;
                out_handle_o      <= 4'(best_i);
                out_task_o        <= best_task_i;
                out_has_handler_o <= best_hh_i;
                out_handler_tag_o <= best_tag_i;
                nout_q            <= nout_q + 5'd1;
                // another due entry remains and the beat cap is not reached: this beat is not the last
                if (nout_q != 5'(MaxOut - 1) && sts_i.have_more) begin
                  last_o <= 1'b0;
                  more_q <= 1'b1;
                end
              end else begin
                kind_o <= KIND_ACK;
              end
            end
            default: kind_o <= KIND_ACK;
          endcase
        end
        S_OUT: if (!out_busy) begin
          state_q <= more_q ? S_SCAN : S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/sorted_timer_queue.sv]
// ----------------------------------------------------------------------------
// sorted_timer_queue: table of one-shot timers released in expiry order
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  cfg      | cfg_valid/ready    | cfg_data_i = ms_per_tick
//  in       | in_valid/in_stall  | mode, task_id, delay_ms, slot_handle, ...
//  out      | out_valid/stall    | kind, out_handle, out_task, ..., last
//
// Add and update: the serial divide converts the delay to ticks; an add's
// free-slot scan runs beside it.
// Remove and a quiet tick: one slot scan.
// A tick that expires n entries: one scan per beat.
// Reset clears the tick count and all valid bits; no clearing pass.
// A stalled output beat holds the sequencer; no new beat enters meanwhile.
//
// Each tick scan also notes whether a second due entry exists, so the beat
// that takes the last due entry, or the MaxOut-th beat of a tick, carries last.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_timer_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [9:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [31:0] delay_ms_i,
  input  wire logic [3:0]  slot_handle_i,
  input  wire logic        has_handler_i,
  input  wire logic [7:0]  handler_tag_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [3:0]       out_handle_o,
  output logic [7:0]       out_task_o,
  output logic             out_has_handler_o,
  output logic [7:0]       out_handler_tag_o,
  output logic             last_o
);
  import stq_pkg::*;

  logic [9:0] ms_per_tick_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [SlotW-1:0] best, free;
  logic [7:0] best_task, best_tag;
  logic best_hh;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ms_per_tick_q <= 10'd10;
    else if (cfg_valid_i) ms_per_tick_q <= cfg_data_i;
  end

  stq_datapath u_dp (
    .clk_i, .rst_ni, .ms_per_tick_i(ms_per_tick_q),
    .mode_i, .task_id_i, .delay_ms_i, .slot_handle_i, .has_handler_i,
    .handler_tag_i, .cmd_i(cmd), .sts_o(sts), .best_o(best), .free_o(free),
    .best_task_o(best_task), .best_hh_o(best_hh), .best_tag_o(best_tag)
  );

  stq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .kind_o, .out_handle_o, .out_task_o, .out_has_handler_o,
    .out_handler_tag_o, .last_o, .cmd_o(cmd), .sts_i(sts), .best_i(best),
    .free_i(free), .best_task_i(best_task), .best_hh_i(best_hh),
    .best_tag_i(best_tag)
  );
endmodule
`default_nettype wire

[design/stq_checker.sv]
// ----------------------------------------------------------------------------
// stq_checker: port-level checks of the sorted timer queue
// Output beat hold under stall, one operation at a time, last on single-beat results.
// ----------------------------------------------------------------------------
`default_nettype none
module stq_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] kind_o,
  input wire logic       last_o
);
  import stq_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o))
    else $error("output beat dropped under stall");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_EXPIRED |-> last_o)
    else $error("single-beat result without last");
endmodule

bind sorted_timer_queue stq_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .kind_o, .last_o
);
`default_nettype wire

[verif/sorted_timer_queue_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_check: prediction and comparison for the timer queue
// Watches the config, input and output channels. Every accepted input beat
// runs through a local copy of the timer table, and the expected output
// beats are queued. Each accepted output beat is compared with the oldest.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_timer_queue_check
  import stq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [9:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [31:0] delay_ms_i,
  input  wire logic [3:0]  slot_handle_i,
  input  wire logic        has_handler_i,
  input  wire logic [7:0]  handler_tag_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [3:0]  out_handle_i,
  input  wire logic [7:0]  out_task_i,
  input  wire logic        out_has_handler_i,
  input  wire logic [7:0]  out_handler_tag_i,
  input  wire logic        last_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] handle;
    logic [7:0] owner;
    logic       has_hdl;
    logic [7:0] tag;
    logic       last;
  } timer_beat_t;

  timer_beat_t want_q[$];

  logic [9:0]  ms_per_tick;
  logic [31:0] tick_count;
  logic        slot_live   [TimerSlots];
  logic [31:0] slot_expiry [TimerSlots];
  logic [7:0]  slot_owner  [TimerSlots];
  logic        slot_has_hdl[TimerSlots];
  logic [7:0]  slot_tag    [TimerSlots];

  function automatic timer_beat_t make_beat(kind_e k, int h, logic [7:0] o,
                                            logic hh, logic [7:0] t, logic l);
    timer_beat_t b;
    b.kind = k;
    b.handle = h[3:0];
    b.owner = o;
    b.has_hdl = hh;
    b.tag = t;
    b.last = l;
    return b;
  endfunction

  function automatic logic [31:0] expiry_for(logic [31:0] delay);
    logic [31:0] div;
    div = (ms_per_tick == 0) ? 32'd1 : {22'd0, ms_per_tick};
    return tick_count + delay / div;
  endfunction

  task automatic run_timer_op(mode_e m, logic [7:0] owner, logic [31:0] delay,
                              logic [3:0] slot, logic hh, logic [7:0] tag);
    int free_slot;
    int best;
    int n;
    case (m)
      MODE_ADD: begin
        free_slot = -1;
        for (int i = 0; i < TimerSlots; i++)
          if (!slot_live[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          want_q.push_back(make_beat(KIND_ERROR, 0, 0, 0, 0, 1));
        end else begin
          slot_live[free_slot] = 1'b1;
          slot_expiry[free_slot] = expiry_for(delay);
          slot_owner[free_slot] = owner;
          slot_has_hdl[free_slot] = hh;
          slot_tag[free_slot] = hh ? tag : 8'd0;
          want_q.push_back(make_beat(KIND_ADDED, free_slot, 0, 0, 0, 1));
        end
      end
      MODE_UPDATE: begin
        if (int'(slot) < TimerSlots && slot_live[slot]) begin
          slot_expiry[slot] = expiry_for(delay);
          want_q.push_back(make_beat(KIND_ACK, 0, 0, 0, 0, 1));
        end else begin
          want_q.push_back(make_beat(KIND_ERROR, 0, 0, 0, 0, 1));
        end
      end
      MODE_REMOVE: begin
        for (int i = 0; i < TimerSlots; i++)
          if (slot_live[i] && slot_owner[i] == owner) slot_live[i] = 1'b0;
        want_q.push_back(make_beat(KIND_ACK, 0, 0, 0, 0, 1));
      end
      default: begin
        tick_count = tick_count + 1;
        n = 0;
        while (n < MaxOut) begin
          best = -1;
          for (int i = 0; i < TimerSlots; i++)
            if (slot_live[i] && slot_expiry[i] <= tick_count &&
                (best < 0 || slot_expiry[i] < slot_expiry[best]))
              best = i;
          if (best < 0) break;
          want_q.push_back(make_beat(KIND_EXPIRED, best, slot_owner[best],
                                     slot_has_hdl[best], slot_tag[best], 0));
          slot_live[best] = 1'b0;
          n++;
        end
        if (n == 0) want_q.push_back(make_beat(KIND_ACK, 0, 0, 0, 0, 1));
        else want_q[$].last = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    timer_beat_t got;
    timer_beat_t exp_b;
    if (!rst_ni) begin
      ms_per_tick = 10'd10;
      tick_count = 0;
      for (int i = 0; i < TimerSlots; i++) slot_live[i] = 1'b0;
      want_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{kind_i, out_handle_i, out_task_i, out_has_handler_i,
                out_handler_tag_i, last_i};
        if (want_q.size() == 0) begin
          $display("%0t: output beat with nothing expected: actual %p", $time, got);
          fail_count_o++;
        end else begin
          exp_b = want_q.pop_front();
          if (got !== exp_b) begin
            $display("%0t: output mismatch: expected %p actual %p",
                     $time, exp_b, got);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) ms_per_tick = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        run_timer_op(mode_e'(mode_i), task_id_i, delay_ms_i, slot_handle_i,
                     has_handler_i, handler_tag_i);
    end
    pending_o = want_q.size();
  end

endmodule
`default_nettype wire

[verif/sorted_timer_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_test: regression top for the sorted timer queue
// Directed beats cover quiet ticks, table full, bad slots, ties, wrap and
// removal; random phases follow at several tick divisors with random gaps
// on both channels. The checker predicts and compares; this module judges.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_timer_queue_test;
  import stq_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int DrainWait = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = MODE_TICK;
  logic [7:0]  task_id_i = '0;
  logic [31:0] delay_ms_i = '0;
  logic [3:0]  slot_handle_i = '0;
  logic        has_handler_i = 1'b0;
  logic [7:0]  handler_tag_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [3:0]  out_handle_o;
  logic [7:0]  out_task_o;
  logic        out_has_handler_o;
  logic [7:0]  out_handler_tag_o;
  logic        last_o;

  int          fail_count;
  int          pending;
  logic        calm = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [9:0]  cur_ms = 10'd10;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_timer_queue dut (.*);

  sorted_timer_queue_check chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .mode_i, .task_id_i, .delay_ms_i, .slot_handle_i, .has_handler_i,
    .handler_tag_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .kind_i(kind_o), .out_handle_i(out_handle_o), .out_task_i(out_task_o),
    .out_has_handler_i(out_has_handler_o), .out_handler_tag_i(out_handler_tag_o),
    .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver backpressure in bursts
  always @(posedge clk_i) begin
    if (calm || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("sorted_timer_queue regression: fail");
      $finish;
    end
  end

  task automatic send_op(mode_e m, logic [7:0] owner, logic [31:0] delay,
                         logic [3:0] slot, logic hh, logic [7:0] tag);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    task_id_i <= owner;
    delay_ms_i <= delay;
    slot_handle_i <= slot;
    has_handler_i <= hh;
    handler_tag_i <= tag;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic set_ms_per_tick(logic [9:0] v);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_ms = v;
  endtask

  task automatic random_beats(int count);
    int pick;
    int unit;
    logic [31:0] delay;
    logic [7:0] owner;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      unit = (cur_ms == 0) ? 1 : int'(cur_ms);
      if ($urandom_range(0, 9) == 0) delay = $urandom;
      else delay = unit * $urandom_range(0, 6) + $urandom_range(0, unit - 1);
      owner = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      if (pick < 40)
        send_op(MODE_TICK, 8'($urandom), $urandom, 4'($urandom), 1'($urandom),
                8'($urandom));
      else if (pick < 75)
        send_op(MODE_ADD, owner, delay, 4'($urandom), 1'($urandom), 8'($urandom));
      else if (pick < 87)
        send_op(MODE_UPDATE, owner, delay, 4'($urandom), 1'($urandom),
                8'($urandom));
      else
        send_op(MODE_REMOVE, owner, delay, 4'($urandom), 1'($urandom),
                8'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: quiet tick, ties at a delay of zero ticks, fill to full, update, remove
    send_op(MODE_TICK, 8'hff, 32'hffff_ffff, 4'hf, 1'b1, 8'hff);
    send_op(MODE_ADD, 8'h01, 32'd0, 4'h0, 1'b1, 8'hff);
    send_op(MODE_ADD, 8'h02, 32'd5, 4'h0, 1'b0, 8'hff);
    send_op(MODE_ADD, 8'hff, 32'hffff_ffff, 4'h0, 1'b1, 8'h00);
    for (int i = 0; i < 13; i++)
      send_op(MODE_ADD, 8'h03, 32'd100 + i, 4'h0, 1'b1, 8'(i));
    send_op(MODE_ADD, 8'h04, 32'd10, 4'h0, 1'b1, 8'h55);
    send_op(MODE_UPDATE, 8'h00, 32'd20, 4'hf, 1'b0, 8'h00);
    send_op(MODE_REMOVE, 8'h03, 32'd0, 4'h0, 1'b0, 8'h00);
    send_op(MODE_UPDATE, 8'h00, 32'd0, 4'h5, 1'b0, 8'h00);
    send_op(MODE_TICK, 8'h00, 32'd0, 4'h0, 1'b0, 8'h00);
    send_op(MODE_TICK, 8'h00, 32'd0, 4'h0, 1'b0, 8'h00);
    send_op(MODE_REMOVE, 8'hff, 32'd0, 4'h0, 1'b0, 8'h00);

    // divisor 1: a delay near the top wraps the expiry below the count
    set_ms_per_tick(10'd1);
    send_op(MODE_ADD, 8'h09, 32'hffff_ffff, 4'h0, 1'b1, 8'haa);
    send_op(MODE_TICK, 8'h00, 32'd0, 4'h0, 1'b0, 8'h00);
    random_beats(34);
    set_ms_per_tick(10'd1023);
    random_beats(34);
    set_ms_per_tick(10'd0);
    random_beats(34);
    set_ms_per_tick(10'd1000);
    random_beats(34);
    set_ms_per_tick(10'($urandom_range(2, 999)));
    random_beats(34);
    set_ms_per_tick(10'd10);
    calm = 1'b1;
    random_beats(34);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("sorted_timer_queue regression: pass");
    else
      $display("sorted_timer_queue regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
